// ----- rtl/fcs_pkg.sv -----
`timescale 1ns / 1ps

package fcs_pkg;

	localparam int CLUSTER_W    = 12;
	localparam int ADDR_W       = 13;
	localparam int BYTE_W       = 8;
	localparam int POS_W        = 32;
	localparam int OFFSET_W     = 16;
	localparam int SECTOR_W     = 20;
	localparam int SPC_W        = 8;
	localparam int DSS_W        = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int SECT_LOG2    = 9;
	localparam int SECTOR_BYTES = 512;
	localparam int HOPS_W       = POS_W - SECT_LOG2;
	localparam int LEN_W        = 13;

	localparam int DEF_TABLE_SECTORS = 12;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_SEEK   = 2'd2;

	localparam logic REG_SPC = 1'b0;
	localparam logic REG_DSS = 1'b1;

	localparam logic [SPC_W-1:0]     SPC_RESET   = 8'd1;
	localparam logic [SPC_W-1:0]     SPC_MAX     = 8'd128;
	localparam logic [DSS_W-1:0]     DSS_RESET   = 16'd33;
	localparam logic [CLUSTER_W-1:0] EOC_MIN     = 12'hFF8;
	localparam logic [LEN_W-1:0]     CHAIN_LIMIT = 13'd4096;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic                 go;
		logic [CLUSTER_W-1:0] cluster;
	} tbl_req_t;

	typedef struct packed {
		logic                 done;
		logic [CLUSTER_W-1:0] next;
	} tbl_rsp_t;

	typedef struct packed {
		logic              go;
		logic [HOPS_W-1:0] dividend;
		logic [LEN_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [HOPS_W-1:0] quotient;
		logic [LEN_W-1:0]  remainder;
	} div_rsp_t;

endpackage

// ----- rtl/fcs_div.sv -----
`timescale 1ns / 1ps

module fcs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fcs_pkg::div_req_t req,
	output fcs_pkg::div_rsp_t rsp
);
	import fcs_pkg::*;

	localparam int CNT_W = $clog2(HOPS_W + 1);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  rem_q;
	logic [HOPS_W-1:0] quo_q;
	logic [LEN_W-1:0]  dvs_q;

	logic [LEN_W:0]    shifted;
	logic              ge;
	logic [LEN_W:0]    diff;

	always_comb begin
		shifted = {rem_q, quo_q[HOPS_W-1]};
		ge      = (shifted >= {1'b0, dvs_q});
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(HOPS_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
			quo_q <= {quo_q[HOPS_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- rtl/fcs_fat.sv -----
`timescale 1ns / 1ps

module fcs_fat #(
	parameter int TABLE_SECTORS = fcs_pkg::DEF_TABLE_SECTORS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fcs_pkg::tbl_wr_t  wr,
	input  fcs_pkg::tbl_req_t req,
	output fcs_pkg::tbl_rsp_t rsp
);
	import fcs_pkg::*;

	localparam int TABLE_BYTES = TABLE_SECTORS * SECTOR_BYTES;
	localparam int IDX_W       = $clog2(TABLE_BYTES);
	localparam logic [ADDR_W:0] TABLE_LIMIT = (ADDR_W + 1)'(TABLE_BYTES);

	typedef enum logic [1:0] {F_IDLE, F_B0, F_B1} fstate_t;

	fstate_t              fstate_q;
	logic                 done_q;
	logic [CLUSTER_W-1:0] next_q;
	logic [ADDR_W-1:0]    off_q;
	logic                 odd_q;
	logic                 oor_q;
	logic [BYTE_W-1:0]    lo_q;
	logic [BYTE_W-1:0]    rdata_q;
	logic [BYTE_W-1:0]    store_q [TABLE_BYTES];

	logic [ADDR_W-1:0]    off_c;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 oor_c;
	logic [BYTE_W-1:0]    hi_c;
	logic [2*BYTE_W-1:0]  word_c;
	logic [CLUSTER_W-1:0] entry_c;

	always_comb begin
		off_c   = {1'b0, req.cluster} + {2'b0, req.cluster[CLUSTER_W-1:1]};
		rd_addr = (fstate_q == F_B0) ? off_q + 1'b1 : off_c;
		oor_c   = ({1'b0, rd_addr} >= TABLE_LIMIT);
		hi_c    = oor_q ? '0 : rdata_q;
		word_c  = {hi_c, lo_q};
		entry_c = odd_q ? word_c[15:4] : word_c[11:0];
	end

	always_ff @(posedge clk) begin
		rdata_q <= store_q[rd_addr[IDX_W-1:0]];
		if (wr.en && ({1'b0, wr.addr} < TABLE_LIMIT))
			store_q[wr.addr[IDX_W-1:0]] <= wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstate_q <= F_IDLE;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (fstate_q)
				F_IDLE: begin
					if (req.go) begin
						off_q    <= off_c;
						odd_q    <= req.cluster[0];
						oor_q    <= oor_c;
						fstate_q <= F_B0;
					end
				end
				F_B0: begin
					lo_q     <= oor_q ? '0 : rdata_q;
					oor_q    <= oor_c;
					fstate_q <= F_B1;
				end
				F_B1: begin
					next_q   <= (entry_c >= EOC_MIN || entry_c == '0) ? '0 : entry_c;
					done_q   <= 1'b1;
					fstate_q <= F_IDLE;
				end
				default: fstate_q <= F_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.next = next_q;

endmodule

// ----- rtl/fat12_chain_seek_engine.sv -----
`timescale 1ns / 1ps

// Load: the byte is written when the command is taken, no result, busy stays low.
// Lookup: the result is strobed once the table lookup of start_cluster returns.
// Seek: the shared 23-step divider gives the hop count, then one table lookup per hop;
//   past 4096 hops, a loop is sought; if found, the remaining hops are taken modulo its length.
// Results are strobed for one cycle and cannot be stalled; busy is high meanwhile.
// Reset clears control and resets spc and dss; the table is undefined until loaded.
module fat12_chain_seek_engine #(
	parameter int TABLE_SECTORS = fcs_pkg::DEF_TABLE_SECTORS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        cmd,
	input  logic [fcs_pkg::ADDR_W-1:0]        table_address,
	input  logic [fcs_pkg::BYTE_W-1:0]        table_byte,
	input  logic [fcs_pkg::CLUSTER_W-1:0]     start_cluster,
	input  logic [fcs_pkg::POS_W-1:0]         byte_position,
	output logic                              done,
	output logic [fcs_pkg::CLUSTER_W-1:0]     cluster,
	output logic [fcs_pkg::OFFSET_W-1:0]      cluster_offset,
	output logic [fcs_pkg::SECTOR_W-1:0]      sector,
	output logic                              end_of_chain,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [fcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import fcs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_DIVH, S_WALK1, S_CYC, S_DIVM, S_WALK2, S_MUL, S_SUM
	} state_t;

	state_t               state_q;
	logic                 wait_q;
	logic                 done_q;
	logic [SPC_W-1:0]     spc_q;
	logic [DSS_W-1:0]     dss_q;
	logic [SPC_W-1:0]     spc_eff_q;
	logic [SECT_LOG2-1:0] pos_lo_q;
	logic [SPC_W-1:0]     rem_q;
	logic [CLUSTER_W-1:0] cur_q;
	logic [CLUSTER_W-1:0] t_q;
	logic [LEN_W-1:0]     len_q;
	logic [HOPS_W-1:0]    n_q;
	logic [HOPS_W-1:0]    rest_q;
	logic [SECTOR_W-1:0]  prod_q;
	div_req_t             div_req_q;

	logic [CLUSTER_W-1:0] cluster_q;
	logic [OFFSET_W-1:0]  offset_q;
	logic [SECTOR_W-1:0]  sector_q;
	logic                 eoc_q;

	tbl_wr_t              tbl_wr;
	tbl_req_t             tbl_req;
	tbl_rsp_t             tbl_rsp;
	div_rsp_t             div_rsp;

	logic [SPC_W-1:0]     spc_clamp;
	logic [SECTOR_W-1:0]  cur_m2;
	logic [SECTOR_W+SPC_W-1:0] mul_c;
	logic [SECTOR_W-1:0]  sec_c;
	logic [LEN_W-1:0]     len_nxt;
	logic                 accept;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_comb begin
		spc_clamp = (spc_q == '0) ? SPC_RESET : ((spc_q > SPC_MAX) ? SPC_MAX : spc_q);
		cur_m2    = {{(SECTOR_W-CLUSTER_W){1'b0}}, cur_q} - SECTOR_W'(2);
		mul_c     = cur_m2 * spc_eff_q;
		sec_c     = {{(SECTOR_W-DSS_W){1'b0}}, dss_q} + prod_q
		            + {{(SECTOR_W-SPC_W){1'b0}}, rem_q};
		len_nxt   = len_q + 1'b1;

		tbl_wr.en   = accept && (cmd == CMD_LOAD);
		tbl_wr.addr = table_address;
		tbl_wr.data = table_byte;

		tbl_req.cluster = (state_q == S_CYC) ? t_q : cur_q;
		tbl_req.go      = 1'b0;
		unique case (state_q)
			S_LOOK, S_CYC:   tbl_req.go = !wait_q;
			S_WALK1, S_WALK2: tbl_req.go = !wait_q && (n_q != '0);
			default:         tbl_req.go = 1'b0;
		endcase
	end

	fcs_fat #(
		.TABLE_SECTORS(TABLE_SECTORS)
	) u_fat (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (tbl_wr),
		.req   (tbl_req),
		.rsp   (tbl_rsp)
	);

	fcs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req_q),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wait_q       <= 1'b0;
			done_q       <= 1'b0;
			spc_q        <= SPC_RESET;
			dss_q        <= DSS_RESET;
			div_req_q.go <= 1'b0;
		end else begin
			done_q       <= 1'b0;
			div_req_q.go <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SPC)
					spc_q <= cfg_data[SPC_W-1:0];
				else
					dss_q <= cfg_data[DSS_W-1:0];
			end

			if (tbl_req.go)
				wait_q <= 1'b1;
			else if (tbl_rsp.done)
				wait_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (cmd)
							CMD_LOOKUP: begin
								cur_q   <= start_cluster;
								state_q <= S_LOOK;
							end
							CMD_SEEK: begin
								cur_q              <= start_cluster;
								pos_lo_q           <= byte_position[SECT_LOG2-1:0];
								spc_eff_q          <= spc_clamp;
								div_req_q.go       <= 1'b1;
								div_req_q.dividend <= byte_position[POS_W-1:SECT_LOG2];
								div_req_q.divisor  <= {{(LEN_W-SPC_W){1'b0}}, spc_clamp};
								state_q            <= S_DIVH;
							end
							default: ;
						endcase
					end
				end
				S_LOOK: begin
					if (tbl_rsp.done) begin
						cluster_q <= tbl_rsp.next;
						offset_q  <= '0;
						sector_q  <= '0;
						eoc_q     <= (tbl_rsp.next == '0);
						done_q    <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_DIVH: begin
					if (div_rsp.done) begin
						rem_q <= div_rsp.remainder[SPC_W-1:0];
						if (div_rsp.quotient >= HOPS_W'(CHAIN_LIMIT)) begin
							n_q    <= HOPS_W'(CHAIN_LIMIT);
							rest_q <= div_rsp.quotient - HOPS_W'(CHAIN_LIMIT);
						end else begin
							n_q    <= div_rsp.quotient;
							rest_q <= '0;
						end
						state_q <= S_WALK1;
					end
				end
				S_WALK1, S_WALK2: begin
					if (tbl_rsp.done) begin
						if (tbl_rsp.next == '0) begin
							cluster_q <= '0;
							offset_q  <= '0;
							sector_q  <= '0;
							eoc_q     <= 1'b1;
							done_q    <= 1'b1;
							state_q   <= S_IDLE;
						end else begin
							cur_q <= tbl_rsp.next;
							n_q   <= n_q - 1'b1;
						end
					end else if (!wait_q && n_q == '0) begin
						if (state_q == S_WALK2 || rest_q == '0) begin
							state_q <= S_MUL;
						end else begin
							t_q     <= cur_q;
							len_q   <= '0;
							state_q <= S_CYC;
						end
					end
				end
				S_CYC: begin
					if (tbl_rsp.done) begin
						t_q   <= tbl_rsp.next;
						len_q <= len_nxt;
						if (tbl_rsp.next == cur_q) begin
							div_req_q.go       <= 1'b1;
							div_req_q.dividend <= rest_q;
							div_req_q.divisor  <= len_nxt;
							state_q            <= S_DIVM;
						end else if (tbl_rsp.next == '0 || len_nxt > CHAIN_LIMIT) begin
							n_q     <= rest_q;
							state_q <= S_WALK2;
						end
					end
				end
				S_DIVM: begin
					if (div_rsp.done) begin
						n_q     <= {{(HOPS_W-LEN_W){1'b0}}, div_rsp.remainder};
						state_q <= S_WALK2;
					end
				end
				S_MUL: begin
					prod_q  <= mul_c[SECTOR_W-1:0];
					state_q <= S_SUM;
				end
				S_SUM: begin
					cluster_q <= cur_q;
					offset_q  <= {rem_q[OFFSET_W-SECT_LOG2-1:0], pos_lo_q};
					sector_q  <= sec_c;
					eoc_q     <= 1'b0;
					done_q    <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done           = done_q;
	assign cluster        = cluster_q;
	assign cluster_offset = offset_q;
	assign sector         = sector_q;
	assign end_of_chain   = eoc_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in progress");

	a_eoc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && end_of_chain |-> cluster == '0 && cluster_offset == '0 && sector == '0)
		else $error("end of chain result carries nonzero fields");

	a_tbl_rsp_pending: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_rsp.done |-> wait_q)
		else $error("table response with no lookup outstanding");

	a_no_go_while_wait: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q |-> !tbl_req.go)
		else $error("table lookup issued while one is outstanding");

endmodule
